// ===== src/tsse_pkg.sv =====
package tsse_pkg;

    localparam int TAG_SLOTS    = 32;
    localparam int ENTITY_SLOTS = 256;
    localparam int TAG_W        = 5;
    localparam int ENT_W        = 8;
    localparam int CNT_W        = 9;
    localparam int MASK_W       = 32;
    localparam int SLOT_W       = TAG_W + ENT_W;

    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_ERASE   = 3'd2;
    localparam logic [2:0] REQ_ITERATE = 3'd3;
    localparam logic [2:0] REQ_COPY    = 3'd4;
    localparam logic [2:0] REQ_RESET   = 3'd5;
    localparam logic [2:0] REQ_LOOKUP  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_UNREG = 2'd2;

    typedef struct packed {
        logic [7:0]        index;
        logic [TAG_W-1:0]  tag;
        logic [ENT_W-1:0]  second_entity;
        logic [ENT_W-1:0]  entity;
        logic [MASK_W-1:0] key_mask;
        logic [2:0]        req_type;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ENT_W-1:0] entity_out;
    } res_t;

    // Index of the lowest set bit, zero when the mask is empty.
    function automatic logic [TAG_W-1:0] low_tag(input logic [MASK_W-1:0] m);
        logic [TAG_W-1:0] r;
        r = '0;
        for (int k = MASK_W - 1; k >= 0; k--)
        begin
            if (m[k])
            begin
                r = TAG_W'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== src/tsse_ctrl.sv =====
module tsse_ctrl
    import tsse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MASK_W-1:0] registered_tags,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRC    = 4'd1;
    localparam logic [3:0] S_DST    = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_RMW    = 4'd5;
    localparam logic [3:0] S_WB     = 4'd6;
    localparam logic [3:0] S_IDATA  = 4'd7;
    localparam logic [3:0] S_LRD    = 4'd8;
    localparam logic [3:0] S_LENT   = 4'd9;
    localparam logic [3:0] S_LCHK   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]        state_reg;
    req_t              req_reg;
    res_t              res_reg;
    logic [MASK_W-1:0] src_reg;
    logic [MASK_W-1:0] dst_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] cur_reg;
    logic [MASK_W-1:0] pend_reg;
    logic [ENT_W-1:0]  tgt_reg;
    logic              add_reg;
    logic [TAG_W-1:0]  wtag_reg;
    logic [TAG_W-1:0]  lk_tag_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [ENT_W-1:0]  cand_reg;

    logic [CNT_W-1:0]  cnt_reg [TAG_SLOTS];
    logic [ENTITY_SLOTS-1:0] et_vld_reg;

    logic [MASK_W-1:0] et_mem [ENTITY_SLOTS];
    logic [MASK_W-1:0] et_rdata_reg;
    logic              et_rvld_reg;
    logic [ENT_W-1:0]  et_ra;
    logic              et_we;
    logic [MASK_W-1:0] et_wd;

    logic [ENT_W-1:0]  dense_mem [TAG_SLOTS*ENTITY_SLOTS];
    logic [ENT_W-1:0]  dense_rdata_reg;
    logic [SLOT_W-1:0] dense_ra;
    logic [SLOT_W-1:0] dense_wa;
    logic              dense_we;
    logic [ENT_W-1:0]  dense_wd;

    logic [ENT_W-1:0]  sparse_mem [TAG_SLOTS*ENTITY_SLOTS];
    logic [ENT_W-1:0]  sparse_rdata_reg;
    logic [SLOT_W-1:0] sparse_ra;
    logic [SLOT_W-1:0] sparse_wa;
    logic              sparse_we;
    logic [ENT_W-1:0]  sparse_wd;

    logic [TAG_W-1:0]  cnt_ra;
    logic [CNT_W-1:0]  cnt_rd;
    logic [MASK_W-1:0] tags_rd;
    logic [TAG_W-1:0]  walk_tag;
    logic [CNT_W-1:0]  cnt_dec;
    logic [MASK_W-1:0] reg_mask;
    logic [MASK_W-1:0] m_in;
    logic [1:0]        dec_status;

    assign reg_mask = {registered_tags[MASK_W-1:1], 1'b0};
    assign m_in     = {req_reg.key_mask[MASK_W-1:1], 1'b0};
    assign tags_rd  = et_rvld_reg ? et_rdata_reg : '0;
    assign walk_tag = low_tag(pend_reg);
    assign cnt_rd   = cnt_reg[cnt_ra];
    assign cnt_dec  = cnt_rd - CNT_W'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        unique case (state_reg)
            S_DECIDE: cnt_ra = req_reg.tag;
            S_LRD:    cnt_ra = lk_tag_reg;
            S_RMW:    cnt_ra = wtag_reg;
            default:  cnt_ra = walk_tag;
        endcase
    end

    // Status of the request, decided once both entity masks are known.
    always_comb
    begin
        dec_status = ST_OK;
        case (req_reg.req_type) inside
            REQ_ADD, REQ_REMOVE:
            begin
                if (req_reg.entity == '0 || m_in == '0)
                    dec_status = ST_ZERO;
                else if ((m_in & ~reg_mask) != '0)
                    dec_status = ST_UNREG;
            end
            REQ_ERASE:
            begin
                if (req_reg.entity == '0)
                    dec_status = ST_ZERO;
                else if ((src_reg & ~reg_mask) != '0)
                    dec_status = ST_UNREG;
            end
            REQ_COPY:
            begin
                if (req_reg.entity == '0 || req_reg.second_entity == '0)
                    dec_status = ST_ZERO;
                else if ((src_reg & ~reg_mask) != '0)
                    dec_status = ST_UNREG;
            end
            REQ_ITERATE:
            begin
                if (req_reg.tag == '0)
                    dec_status = ST_ZERO;
                else if (!registered_tags[req_reg.tag])
                    dec_status = ST_UNREG;
            end
            REQ_LOOKUP:
            begin
                if (m_in == '0)
                    dec_status = ST_ZERO;
                else if ((m_in & ~reg_mask) != '0)
                    dec_status = ST_UNREG;
            end
            default: ;
        endcase
    end

    // Memory port steering.
    always_comb
    begin
        et_ra     = req_reg.entity;
        et_we     = 1'b0;
        et_wd     = add_reg ? (cur_reg | mask_reg) : (cur_reg & ~mask_reg);
        dense_ra  = {walk_tag, cnt_dec[ENT_W-1:0]};
        dense_we  = 1'b0;
        dense_wa  = {walk_tag, cnt_rd[ENT_W-1:0]};
        dense_wd  = tgt_reg;
        sparse_ra = {walk_tag, tgt_reg};
        sparse_we = 1'b0;
        sparse_wa = {walk_tag, tgt_reg};
        sparse_wd = cnt_rd[ENT_W-1:0];
        unique case (state_reg)
            S_IDLE: et_ra = req.entity;
            S_SRC:  et_ra = req_reg.second_entity;
            S_DECIDE: dense_ra = {req_reg.tag, req_reg.index};
            S_WALK:
            begin
                if (add_reg && (pend_reg != '0) && (cnt_rd < CNT_W'(ENTITY_SLOTS)))
                begin
                    dense_we  = 1'b1;
                    sparse_we = 1'b1;
                end
            end
            S_RMW:
            begin
                dense_we  = 1'b1;
                dense_wa  = {wtag_reg, sparse_rdata_reg};
                dense_wd  = dense_rdata_reg;
                sparse_we = 1'b1;
                sparse_wa = {wtag_reg, dense_rdata_reg};
                sparse_wd = sparse_rdata_reg;
            end
            S_WB: et_we = 1'b1;
            S_LRD: dense_ra = {lk_tag_reg, pos_reg[ENT_W-1:0]};
            S_LENT: et_ra = dense_rdata_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (et_we)
        begin
            et_mem[tgt_reg] <= et_wd;
        end
        et_rdata_reg <= et_mem[et_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_wa] <= dense_wd;
        end
        dense_rdata_reg <= dense_mem[dense_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sparse_we)
        begin
            sparse_mem[sparse_wa] <= sparse_wd;
        end
        sparse_rdata_reg <= sparse_mem[sparse_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            et_vld_reg  <= '0;
            et_rvld_reg <= 1'b0;
            for (int k = 0; k < TAG_SLOTS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            et_rvld_reg <= et_vld_reg[et_ra];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        state_reg <= S_SRC;
                    end
                end
                S_SRC:
                begin
                    src_reg   <= tags_rd;
                    state_reg <= S_DST;
                end
                S_DST:
                begin
                    dst_reg   <= tags_rd;
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    res_reg <= '{status: dec_status, entity_out: '0};
                    if (dec_status != ST_OK)
                        state_reg <= S_DONE;
                    else
                    begin
                        case (req_reg.req_type) inside
                            REQ_ADD, REQ_REMOVE:
                            begin
                                add_reg   <= (req_reg.req_type == REQ_ADD);
                                mask_reg  <= m_in;
                                cur_reg   <= src_reg;
                                tgt_reg   <= req_reg.entity;
                                pend_reg  <= (req_reg.req_type == REQ_ADD) ?
                                             (m_in & ~src_reg) : (m_in & src_reg);
                                state_reg <= S_WALK;
                            end
                            REQ_ERASE:
                            begin
                                if (src_reg == '0)
                                    state_reg <= S_DONE;
                                else
                                begin
                                    add_reg   <= 1'b0;
                                    mask_reg  <= src_reg;
                                    cur_reg   <= src_reg;
                                    tgt_reg   <= req_reg.entity;
                                    pend_reg  <= src_reg;
                                    state_reg <= S_WALK;
                                end
                            end
                            REQ_COPY:
                            begin
                                if (src_reg == '0)
                                    state_reg <= S_DONE;
                                else
                                begin
                                    add_reg   <= 1'b1;
                                    mask_reg  <= src_reg;
                                    cur_reg   <= dst_reg;
                                    tgt_reg   <= req_reg.second_entity;
                                    pend_reg  <= src_reg & ~dst_reg;
                                    state_reg <= S_WALK;
                                end
                            end
                            REQ_ITERATE:
                            begin
                                if (CNT_W'(req_reg.index) < cnt_rd)
                                    state_reg <= S_IDATA;
                                else
                                    state_reg <= S_DONE;
                            end
                            REQ_RESET:
                            begin
                                et_vld_reg <= '0;
                                for (int k = 0; k < TAG_SLOTS; k++)
                                begin
                                    cnt_reg[k] <= '0;
                                end
                                state_reg <= S_DONE;
                            end
                            REQ_LOOKUP:
                            begin
                                lk_tag_reg <= low_tag(m_in);
                                pos_reg    <= '0;
                                state_reg  <= S_LRD;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (pend_reg == '0)
                    begin
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        pend_reg[walk_tag] <= 1'b0;
                        wtag_reg <= walk_tag;
                        if (add_reg)
                        begin
                            if (cnt_rd < CNT_W'(ENTITY_SLOTS))
                                cnt_reg[walk_tag] <= cnt_rd + CNT_W'(1);
                        end
                        else if (cnt_rd != '0)
                        begin
                            state_reg <= S_RMW;
                        end
                    end
                end
                S_RMW:
                begin
                    cnt_reg[wtag_reg] <= cnt_dec;
                    state_reg <= S_WALK;
                end
                S_WB:
                begin
                    et_vld_reg[tgt_reg] <= 1'b1;
                    res_reg   <= '{status: ST_OK, entity_out: '0};
                    state_reg <= S_DONE;
                end
                S_IDATA:
                begin
                    res_reg.entity_out <= dense_rdata_reg;
                    state_reg <= S_DONE;
                end
                S_LRD:
                begin
                    if (pos_reg >= cnt_rd)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_LENT;
                end
                S_LENT:
                begin
                    cand_reg  <= dense_rdata_reg;
                    state_reg <= S_LCHK;
                end
                S_LCHK:
                begin
                    if ((tags_rd & m_in) == m_in)
                    begin
                        res_reg.entity_out <= cand_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + CNT_W'(1);
                        state_reg <= S_LRD;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/tag_sparse_set_engine.sv =====
// Tag sparse-set engine.
// Requests enter on the s_axis channel, one at a time; tdata packs req_type,
// key_mask, entity, second_entity, tag and index from bit 0 up. Each request
// yields exactly one result on the m_axis channel with entity_out and status.
// The tag register is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Entity tag masks live in a 256-entry memory, the per-tag dense lists and
// sparse back-indexes in two 8192-entry memories, all with registered reads.
// A request reads its source and destination masks and decides its status; an
// iterate then reads a list entry. The next request is taken in the cycle after
// the result is handed to the output register. Add and copy walk each tag that
// changes, remove and erase also read and rewrite the lists per tag; then the
// walk closes and writes the mask back. Lookup inspects the first requested
// tag's list until an entry matches or the list ends. One request is in flight
// at a time. A one-entry output register holds the result, so the next request
// is taken while the receiver stalls; the engine waits only if a second result
// is ready before the first is taken.
// Reset empties every list and mask at once through per-entity valid bits and
// per-tag counters; the list memories need no clearing pass.
module tag_sparse_set_engine
    import tsse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[2:0], key_mask[34:3], entity[42:35], second_entity[50:43],
    // tag[55:51], index[63:56]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // entity_out[7:0], status[9:8], zero padding above
    output logic [15:0] m_axis_tdata
);

    logic [MASK_W-1:0] registered_tags_reg;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              out_vld_reg;
    res_t              out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            registered_tags_reg <= '0;
        else if (cfg_we)
            registered_tags_reg <= cfg_wdata;
    end

    tsse_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .registered_tags (registered_tags_reg),
        .req_valid       (s_axis_tvalid),
        .req_ready       (s_axis_tready),
        .req             (req_t'(s_axis_tdata)),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // The output register frees the engine as soon as a result is handed over.
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'b0, out_reg};

endmodule

// ===== src/tsse_checker.sv =====
module tsse_checker
    import tsse_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // The engine serves one request at a time.
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3)
        else $error("undefined status code");

    a_err_no_entity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != ST_OK |-> m_axis_tdata[7:0] == 8'd0)
        else $error("entity reported with an error status");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
        else $error("result padding not zero");

endmodule

bind tag_sparse_set_engine tsse_checker u_tsse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
